>>> hw/rtl/bir_pkg.sv
// Shared types and constants of the bilinear image resampler.
// Holds field widths, the register map, the command word passed from the
// front end to the back end, and the configuration reset values.
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 8;

  localparam int COL_W  = $clog2(MAX_SRC_WIDTH);
  localparam int ROW_W  = $clog2(MAX_SRC_HEIGHT);
  localparam int ADDR_W = ROW_W + COL_W;

  localparam int IDX_W     = 12;
  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 24;
  localparam int STEP_W    = 24;
  localparam int SRC_SZ_W  = 9;
  localparam int OUT_SZ_W  = 13;
  localparam int STEP_FRAC = 16;
  localparam int POS_W     = IDX_W + STEP_W;
  localparam int POS_INT_W = POS_W - STEP_FRAC;
  // wide enough for a register value or a MAX size up to 4096
  localparam int EFF_W     = 13;

  localparam int TOP_W = SAMPLE_W + FRAC_BITS + 1;
  localparam int MIX_W = TOP_W + FRAC_BITS + 1;

  localparam int IN_TDATA_W  = 2 * IDX_W + SAMPLE_W;
  localparam int OUT_TDATA_W = VALUE_W;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_OUT_WIDTH  = 3'd2,
    REG_OUT_HEIGHT = 3'd3,
    REG_X_STEP     = 3'd4,
    REG_Y_STEP     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SRC_SZ_W-1:0] src_width;
    logic [SRC_SZ_W-1:0] src_height;
    logic [OUT_SZ_W-1:0] out_width;
    logic [OUT_SZ_W-1:0] out_height;
    logic [STEP_W-1:0]   x_step;
    logic [STEP_W-1:0]   y_step;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    src_width:  9'd256,
    src_height: 9'd256,
    out_width:  13'd256,
    out_height: 13'd256,
    x_step:     24'd65536,
    y_step:     24'd65536
  };

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_QUERY   = 2'd1,
    CMD_OUTSIDE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                    kind;
    logic [ROW_W-1:0]             r0;
    logic [ROW_W-1:0]             r1;
    logic [COL_W-1:0]             c0;
    logic [COL_W-1:0]             c1;
    logic [FRAC_BITS-1:0]         fx;
    logic [FRAC_BITS-1:0]         fy;
    logic signed [SAMPLE_W-1:0]   sample;
  } cmd_t;

endpackage

>>> hw/rtl/bir_regs.sv
// Configuration register file of the resampler, on an APB-style port.
// Depends on bir_pkg for the register map and reset values.
module bir_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bir_pkg::PADDR_W-1:0]  paddr,
  input  logic [bir_pkg::PDATA_W-1:0]  pwdata,
  output logic [bir_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output bir_pkg::cfg_t                cfg
);

  bir_pkg::reg_idx_t idx;
  logic              wr;

  assign idx    = bir_pkg::reg_idx_t'(paddr[bir_pkg::PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bir_pkg::CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        bir_pkg::REG_SRC_WIDTH:  cfg.src_width  <= pwdata[bir_pkg::SRC_SZ_W-1:0];
        bir_pkg::REG_SRC_HEIGHT: cfg.src_height <= pwdata[bir_pkg::SRC_SZ_W-1:0];
        bir_pkg::REG_OUT_WIDTH:  cfg.out_width  <= pwdata[bir_pkg::OUT_SZ_W-1:0];
        bir_pkg::REG_OUT_HEIGHT: cfg.out_height <= pwdata[bir_pkg::OUT_SZ_W-1:0];
        bir_pkg::REG_X_STEP:     cfg.x_step     <= pwdata[bir_pkg::STEP_W-1:0];
        bir_pkg::REG_Y_STEP:     cfg.y_step     <= pwdata[bir_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bir_pkg::REG_SRC_WIDTH:  prdata = bir_pkg::PDATA_W'(cfg.src_width);
      bir_pkg::REG_SRC_HEIGHT: prdata = bir_pkg::PDATA_W'(cfg.src_height);
      bir_pkg::REG_OUT_WIDTH:  prdata = bir_pkg::PDATA_W'(cfg.out_width);
      bir_pkg::REG_OUT_HEIGHT: prdata = bir_pkg::PDATA_W'(cfg.out_height);
      bir_pkg::REG_X_STEP:     prdata = bir_pkg::PDATA_W'(cfg.x_step);
      bir_pkg::REG_Y_STEP:     prdata = bir_pkg::PDATA_W'(cfg.y_step);
      default:                 prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/bir_front.sv
// Front end: accepts input words, classifies them and forms the source
// neighbour coordinates and weights of a query. Depends on bir_pkg.
module bir_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bir_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  bir_pkg::cfg_t                    cfg,
  output logic                             push,
  output bir_pkg::cmd_t                    push_data,
  input  logic                             full
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  localparam int XI_W = bir_pkg::POS_INT_W + 1;

  front_state_t                          state;
  logic                                  action;
  logic [bir_pkg::IDX_W-1:0]             row;
  logic [bir_pkg::IDX_W-1:0]             col;
  logic signed [bir_pkg::SAMPLE_W-1:0]   sample;
  logic [bir_pkg::POS_W-1:0]             px;
  logic [bir_pkg::POS_W-1:0]             py;
  logic                                  keep;
  bir_pkg::cmd_kind_t                    kind;

  logic [bir_pkg::EFF_W-1:0] w_eff, h_eff, w_last, h_last;
  logic [XI_W-1:0]           xi, yi, xi1, yi1;
  logic [bir_pkg::EFF_W-1:0] x0, x1, y0, y1;
  logic                      in_src, in_out;

  // hold off the sender while reset is applied
  assign s_axis_tready = (state == F_IDLE) && !rst;

  always_comb begin
    w_eff = ({4'b0, cfg.src_width} < bir_pkg::EFF_W'(bir_pkg::MAX_SRC_WIDTH)) ?
            bir_pkg::EFF_W'(cfg.src_width) : bir_pkg::EFF_W'(bir_pkg::MAX_SRC_WIDTH);
    h_eff = ({4'b0, cfg.src_height} < bir_pkg::EFF_W'(bir_pkg::MAX_SRC_HEIGHT)) ?
            bir_pkg::EFF_W'(cfg.src_height) : bir_pkg::EFF_W'(bir_pkg::MAX_SRC_HEIGHT);
    w_last = (w_eff == '0) ? '0 : w_eff - 1'b1;
    h_last = (h_eff == '0) ? '0 : h_eff - 1'b1;

    in_src = ({1'b0, row} < h_eff) && ({1'b0, col} < w_eff);
    in_out = ({1'b0, row} < cfg.out_height) && ({1'b0, col} < cfg.out_width);

    xi  = {1'b0, px[bir_pkg::POS_W-1:bir_pkg::STEP_FRAC]};
    yi  = {1'b0, py[bir_pkg::POS_W-1:bir_pkg::STEP_FRAC]};
    xi1 = xi + 1'b1;
    yi1 = yi + 1'b1;
    // clamp both neighbours to the last valid column and row
    x0 = (xi  > XI_W'(w_last)) ? w_last : bir_pkg::EFF_W'(xi);
    x1 = (xi1 > XI_W'(w_last)) ? w_last : bir_pkg::EFF_W'(xi1);
    y0 = (yi  > XI_W'(h_last)) ? h_last : bir_pkg::EFF_W'(yi);
    y1 = (yi1 > XI_W'(h_last)) ? h_last : bir_pkg::EFF_W'(yi1);

    push_data.kind   = kind;
    push_data.sample = sample;
    push_data.fx     = px[bir_pkg::STEP_FRAC-1 -: bir_pkg::FRAC_BITS];
    push_data.fy     = py[bir_pkg::STEP_FRAC-1 -: bir_pkg::FRAC_BITS];
    if (kind == bir_pkg::CMD_LOAD) begin
      push_data.r0 = row[bir_pkg::ROW_W-1:0];
      push_data.r1 = row[bir_pkg::ROW_W-1:0];
      push_data.c0 = col[bir_pkg::COL_W-1:0];
      push_data.c1 = col[bir_pkg::COL_W-1:0];
    end else begin
      push_data.r0 = y0[bir_pkg::ROW_W-1:0];
      push_data.r1 = y1[bir_pkg::ROW_W-1:0];
      push_data.c0 = x0[bir_pkg::COL_W-1:0];
      push_data.c1 = x1[bir_pkg::COL_W-1:0];
    end

    push = (state == F_PUSH) && keep && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (s_axis_tvalid) begin
            action <= s_axis_tuser;
            row    <= s_axis_tdata[bir_pkg::IDX_W-1:0];
            col    <= s_axis_tdata[2*bir_pkg::IDX_W-1:bir_pkg::IDX_W];
            sample <= s_axis_tdata[bir_pkg::IN_TDATA_W-1:2*bir_pkg::IDX_W];
            state  <= F_MUL;
          end
        end
        F_MUL: begin
          px   <= col * cfg.x_step;
          py   <= row * cfg.y_step;
          // drop loads that fall outside the source image
          keep <= action | in_src;
          kind <= !action ? bir_pkg::CMD_LOAD :
                  (in_out ? bir_pkg::CMD_QUERY : bir_pkg::CMD_OUTSIDE);
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!keep || !full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/bir_cmd_fifo.sv
// Short command queue between the resampler front end and back end.
// Depends on bir_pkg for the command word and the queue depth.
module bir_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bir_pkg::cmd_t push_data,
  input  logic          pop,
  output bir_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);

  localparam int CNT_W = bir_pkg::FIFO_PTR_W + 1;

  bir_pkg::cmd_t                   entries [bir_pkg::FIFO_DEPTH];
  logic [bir_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [bir_pkg::FIFO_PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]                count;

  assign head  = entries[rd_ptr];
  assign full  = (count == CNT_W'(bir_pkg::FIFO_DEPTH));
  assign empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(bir_pkg::FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance on push");

endmodule

>>> hw/rtl/bir_back.sv
// Back end: owns the sample memory, carries out loads, reads four neighbours per
// query and blends them, answers an outside query with zero. Depends on bir_pkg.
module bir_back (
  input  logic                              clk,
  input  logic                              rst,
  input  bir_pkg::cmd_t                     head,
  input  logic                              empty,
  output logic                              pop,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser
);

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_READ  = 5'b00010,
    B_MIX1  = 5'b00100,
    B_MIX2  = 5'b01000,
    B_ROUND = 5'b10000
  } back_state_t;

  localparam int MEM_DEPTH = 2 ** bir_pkg::ADDR_W;
  localparam int READS     = 4;
  localparam int W_W       = bir_pkg::FRAC_BITS + 2;
  localparam int SUM_W     = bir_pkg::MIX_W + 1;
  localparam logic [bir_pkg::FRAC_BITS:0] ONE = (bir_pkg::FRAC_BITS+1)'(1 << bir_pkg::FRAC_BITS);
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1 << (bir_pkg::FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((1 << (bir_pkg::VALUE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] VMIN = -SUM_W'(1 << (bir_pkg::VALUE_W - 1));

  logic signed [bir_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic signed [bir_pkg::SAMPLE_W-1:0] rdata;
  logic signed [bir_pkg::SAMPLE_W-1:0] samp [READS];

  back_state_t                     state;
  bir_pkg::cmd_t                   q;
  logic [2:0]                      cnt;
  logic                            mem_we;
  logic [bir_pkg::ADDR_W-1:0]      waddr;
  logic [bir_pkg::ADDR_W-1:0]      raddr;
  logic                            slot_free;
  logic                            out_load;
  logic signed [W_W-1:0]           wx0, wx1, wy0, wy1;
  logic signed [bir_pkg::TOP_W-1:0] top, bot;
  logic signed [bir_pkg::MIX_W-1:0] mix;
  logic signed [SUM_W-1:0]         sum, shifted;
  logic [bir_pkg::VALUE_W-1:0]     sat;

  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign waddr     = {head.r0, head.c0};
  // a result word enters the output register this cycle
  assign out_load  = slot_free &&
                     ((state == B_IDLE && !empty && head.kind == bir_pkg::CMD_OUTSIDE) ||
                      state == B_ROUND);

  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    if (state == B_IDLE && !empty) begin
      unique case (head.kind)
        bir_pkg::CMD_LOAD: begin
          pop    = 1'b1;
          mem_we = 1'b1;
        end
        bir_pkg::CMD_OUTSIDE: pop = slot_free;
        bir_pkg::CMD_QUERY:   pop = 1'b1;
        default:              pop = 1'b1;
      endcase
    end

    case (cnt[1:0])
      2'd0:    raddr = {q.r0, q.c0};
      2'd1:    raddr = {q.r0, q.c1};
      2'd2:    raddr = {q.r1, q.c0};
      default: raddr = {q.r1, q.c1};
    endcase

    wx1 = $signed(W_W'(q.fx));
    wx0 = $signed(W_W'(ONE - {1'b0, q.fx}));
    wy1 = $signed(W_W'(q.fy));
    wy0 = $signed(W_W'(ONE - {1'b0, q.fy}));

    // round half up, then floor by an arithmetic shift
    sum     = $signed({mix[bir_pkg::MIX_W-1], mix} + HALF);
    shifted = sum >>> bir_pkg::FRAC_BITS;
    if (shifted > VMAX) begin
      sat = VMAX[bir_pkg::VALUE_W-1:0];
    end else if (shifted < VMIN) begin
      sat = VMIN[bir_pkg::VALUE_W-1:0];
    end else begin
      sat = shifted[bir_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= head.sample;
    end else begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      m_axis_tvalid <= 1'b0;
      cnt           <= '0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!empty && head.kind == bir_pkg::CMD_OUTSIDE && slot_free) begin
            m_axis_tdata  <= '0;
            m_axis_tuser  <= 1'b1;
          end else if (!empty && head.kind == bir_pkg::CMD_QUERY) begin
            q     <= head;
            cnt   <= '0;
            state <= B_READ;
          end
        end
        B_READ: begin
          // read data is registered, so it arrives in the cycle after its address
          cnt <= cnt + 1'b1;
          if (cnt != '0) begin
            samp[cnt[1:0] - 2'd1] <= rdata;
          end
          if (cnt == 3'(READS)) begin
            state <= B_MIX1;
          end
        end
        B_MIX1: begin
          top   <= samp[0] * wx0 + samp[1] * wx1;
          bot   <= samp[2] * wx0 + samp[3] * wx1;
          state <= B_MIX2;
        end
        B_MIX2: begin
          mix   <= top * wy0 + bot * wy1;
          state <= B_ROUND;
        end
        B_ROUND: begin
          if (slot_free) begin
            m_axis_tdata  <= sat;
            m_axis_tuser  <= 1'b0;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/bilinear_image_resampler_core.sv
// Bilinear image resampler, top level.
// Joins the register file, front end, command queue and back end; uses bir_pkg.
//
// Input stream: s_axis_tuser = 0 loads a source sample at (row, col),
// s_axis_tuser = 1 asks for output pixel (row, col). Loads outside the
// configured source size are dropped and give no result. Every query gives
// one result word: the blended pixel in signed Q.8 with tuser = 0, or zero
// with tuser = 1 when the pixel lies outside the configured output size.
// The front end takes each word through accept, position multiply and
// queue write, holding the write while the queue is full, before it
// accepts the next, and hands it over through a 4-entry command queue.
// The back end stores a load as it takes it; a query passes through four
// reads of the single-port sample memory plus two blend stages and a
// rounding stage, and no new command is taken until its result is registered.
// A result waits in the output register while m_axis_tready is low; the
// front end keeps accepting until the queue fills.
// Reset is synchronous: registers return to their defaults (256 x 256
// source and output, unit steps) and the queue empties. The sample memory
// is not cleared; write every source sample a query will touch. The user must
// write registers over the APB port only while the block is idle, unenforced.
module bilinear_image_resampler_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [bir_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // row[11:0], col[23:12], sample[39:24]
  input  logic                              s_axis_tuser,  // action[0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [bir_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,  // value[23:0]
  output logic                              m_axis_tuser,  // status[0]
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bir_pkg::PADDR_W-1:0]       paddr,
  input  logic [bir_pkg::PDATA_W-1:0]       pwdata,
  output logic [bir_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);

  bir_pkg::cfg_t cfg;
  bir_pkg::cmd_t push_data;
  bir_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  bir_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bir_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg           (cfg),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  bir_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  bir_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> test/tb_bilinear_image_resampler_core.sv
// Testbench for bilinear_image_resampler_core: directed and random load/query streams,
// each result checked against an in-bench bilinear resampler with its own sample store.
// Depends on bir_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_bilinear_image_resampler_core;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_OUTSIDE = 1'b1;

  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 8;
  localparam int PER_PHASE    = 205;
  localparam int TIMEOUT_NS   = 4_000_000;
  localparam int STORE_DEPTH  = bir_pkg::MAX_SRC_WIDTH * bir_pkg::MAX_SRC_HEIGHT;

  typedef struct packed {
    logic [bir_pkg::VALUE_W-1:0] value;
    logic                        status;
  } pixel_t;

  typedef struct {
    int unsigned x0, x1, y0, y1;
    int          fx, fy;
  } spot_t;

  typedef struct packed {
    logic                         act;
    logic [bir_pkg::IDX_W-1:0]    row;
    logic [bir_pkg::IDX_W-1:0]    col;
    logic [bir_pkg::SAMPLE_W-1:0] smp;
    logic                         typed;
    logic [bir_pkg::VALUE_W-1:0]  value;
    logic                         status;
  } probe_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [bir_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;   // row[11:0], col[23:12], sample[39:24]
  logic                            s_axis_tuser = 1'b0; // action[0]
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bir_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // value[23:0]
  logic                            m_axis_tuser;        // status[0]
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [bir_pkg::PADDR_W-1:0]     paddr = '0;
  logic [bir_pkg::PDATA_W-1:0]     pwdata = '0;
  logic [bir_pkg::PDATA_W-1:0]     prdata;
  logic                            pready;

  bilinear_image_resampler_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // mirror of the block's registers and sample store
  bir_pkg::cfg_t                       cfg_mirror = bir_pkg::CFG_RESET;
  logic signed [bir_pkg::SAMPLE_W-1:0] pix_store [STORE_DEPTH];
  bit                                  pix_known [STORE_DEPTH];
  pixel_t                              pending_pixels [$];
  pixel_t                              want;

  bit calm = 1'b0;
  int hold_left = 0;
  int n_words = 0, n_loads = 0, n_dropped = 0;
  int n_queries = 0, n_outside = 0, n_checked = 0, n_errors = 0, n_settings = 0;

  // directed words, run at the reset register values (256 x 256, unit steps)
  probe_t probes [0:22] = '{
    '{ACT_LOAD,  12'd0,    12'd0,    16'h7FFF, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd0,    12'd1,    16'h8000, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd1,    12'd0,    16'h0000, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd1,    12'd1,    16'h0001, 1'b0, 24'h000000, ST_OK},
    '{ACT_QUERY, 12'd0,    12'd0,    16'h0000, 1'b1, 24'h7FFF00, ST_OK},
    '{ACT_LOAD,  12'd0,    12'd2,    16'h0005, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd1,    12'd2,    16'hFFFF, 1'b0, 24'h000000, ST_OK},
    '{ACT_QUERY, 12'd0,    12'd1,    16'hFFFF, 1'b1, 24'h800000, ST_OK},
    '{ACT_LOAD,  12'd2,    12'd0,    16'h0064, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd2,    12'd1,    16'hFF9C, 1'b0, 24'h000000, ST_OK},
    '{ACT_QUERY, 12'd1,    12'd0,    16'h0000, 1'b1, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd0,    12'd255,  16'hFB2E, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd1,    12'd255,  16'h03E7, 1'b0, 24'h000000, ST_OK},
    // right edge: both horizontal neighbours are the last column
    '{ACT_QUERY, 12'd0,    12'd255,  16'h0000, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd255,  12'd255,  16'h3039, 1'b0, 24'h000000, ST_OK},
    '{ACT_QUERY, 12'd255,  12'd255,  16'h0000, 1'b0, 24'h000000, ST_OK},
    // loads outside the source are dropped; row 256 and column 256 alias (0,0) if truncated
    '{ACT_LOAD,  12'd4095, 12'd4095, 16'hFFFF, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd256,  12'd0,    16'h1234, 1'b0, 24'h000000, ST_OK},
    '{ACT_LOAD,  12'd0,    12'd256,  16'h4321, 1'b0, 24'h000000, ST_OK},
    '{ACT_QUERY, 12'd256,  12'd0,    16'h0000, 1'b1, 24'h000000, ST_OUTSIDE},
    '{ACT_QUERY, 12'd0,    12'd256,  16'h0000, 1'b1, 24'h000000, ST_OUTSIDE},
    '{ACT_QUERY, 12'd4095, 12'd4095, 16'hFFFF, 1'b1, 24'h000000, ST_OUTSIDE},
    '{ACT_QUERY, 12'd0,    12'd0,    16'h0000, 1'b1, 24'h7FFF00, ST_OK}
  };

  initial forever #1 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, pending_pixels.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [bir_pkg::SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    return bir_pkg::SAMPLE_W'($urandom);
  endfunction

  function automatic int unsigned src_cols();
    return (cfg_mirror.src_width > bir_pkg::MAX_SRC_WIDTH) ?
           bir_pkg::MAX_SRC_WIDTH : cfg_mirror.src_width;
  endfunction

  function automatic int unsigned src_rows();
    return (cfg_mirror.src_height > bir_pkg::MAX_SRC_HEIGHT) ?
           bir_pkg::MAX_SRC_HEIGHT : cfg_mirror.src_height;
  endfunction

  function automatic int unsigned pin_index(input longint unsigned idx, input int unsigned n);
    int unsigned last;
    last = (n > 0) ? n - 1 : 0;
    return (idx > longint'(last)) ? last : int'(idx);
  endfunction

  // source position of an output pixel: neighbour indexes and fraction weights
  function automatic spot_t locate(input logic [bir_pkg::IDX_W-1:0] r,
                                   input logic [bir_pkg::IDX_W-1:0] c);
    spot_t s;
    longint unsigned px, py;
    px = 64'(c) * 64'(cfg_mirror.x_step);
    py = 64'(r) * 64'(cfg_mirror.y_step);
    s.x0 = pin_index(px >> bir_pkg::STEP_FRAC, src_cols());
    s.x1 = pin_index((px >> bir_pkg::STEP_FRAC) + 1, src_cols());
    s.y0 = pin_index(py >> bir_pkg::STEP_FRAC, src_rows());
    s.y1 = pin_index((py >> bir_pkg::STEP_FRAC) + 1, src_rows());
    s.fx = int'((px >> (bir_pkg::STEP_FRAC - bir_pkg::FRAC_BITS)) &
                64'((1 << bir_pkg::FRAC_BITS) - 1));
    s.fy = int'((py >> (bir_pkg::STEP_FRAC - bir_pkg::FRAC_BITS)) &
                64'((1 << bir_pkg::FRAC_BITS) - 1));
    return s;
  endfunction

  function automatic logic [bir_pkg::VALUE_W-1:0] blend(input spot_t s);
    longint a, b, cc, d, one, top, bot, v, q;
    one = 1 << bir_pkg::FRAC_BITS;
    a   = pix_store[s.y0 * bir_pkg::MAX_SRC_WIDTH + s.x0];
    b   = pix_store[s.y0 * bir_pkg::MAX_SRC_WIDTH + s.x1];
    cc  = pix_store[s.y1 * bir_pkg::MAX_SRC_WIDTH + s.x0];
    d   = pix_store[s.y1 * bir_pkg::MAX_SRC_WIDTH + s.x1];
    top = a * (one - s.fx) + b * s.fx;
    bot = cc * (one - s.fx) + d * s.fx;
    v   = top * (one - s.fy) + bot * s.fy;
    // round half up, then saturate to the signed output range
    q   = (v + (one >>> 1)) >>> bir_pkg::FRAC_BITS;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return bir_pkg::VALUE_W'(q);
  endfunction

  // apply one accepted word to the mirror; returns 1 when it yields a result
  function automatic bit resample_word(input logic act, input logic [bir_pkg::IDX_W-1:0] r,
                                       input logic [bir_pkg::IDX_W-1:0] c,
                                       input logic [bir_pkg::SAMPLE_W-1:0] smp,
                                       output pixel_t px, output bit dropped);
    px = '0;
    dropped = 1'b0;
    if (act == ACT_LOAD) begin
      if (r < src_rows() && c < src_cols()) begin
        pix_store[r * bir_pkg::MAX_SRC_WIDTH + c] = smp;
        pix_known[r * bir_pkg::MAX_SRC_WIDTH + c] = 1'b1;
      end else begin
        dropped = 1'b1;
      end
      return 1'b0;
    end
    if (r >= cfg_mirror.out_height || c >= cfg_mirror.out_width) begin
      px.status = ST_OUTSIDE;
      return 1'b1;
    end
    px.value  = blend(locate(r, c));
    px.status = ST_OK;
    return 1'b1;
  endfunction

  task automatic send_word(input logic act, input logic [bir_pkg::IDX_W-1:0] r,
                           input logic [bir_pkg::IDX_W-1:0] c,
                           input logic [bir_pkg::SAMPLE_W-1:0] smp,
                           input logic typed, input pixel_t typed_px);
    int gap;
    pixel_t px;
    bit gives, dropped;
    gap = pick_gap();
    // valid stays high from the previous word unless a gap is due
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp, c, r};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
    gives = resample_word(act, r, c, smp, px, dropped);
    if (gives) pending_pixels.push_back(typed ? typed_px : px);
    n_words++;
    if (act == ACT_LOAD) begin
      n_loads++;
      if (dropped) n_dropped++;
    end else begin
      n_queries++;
      if (px.status == ST_OUTSIDE) n_outside++;
    end
  endtask

  // load any neighbour a query would read that was never written
  task automatic prime_neighbors(input logic [bir_pkg::IDX_W-1:0] r,
                                 input logic [bir_pkg::IDX_W-1:0] c);
    spot_t s;
    int unsigned ys [2];
    int unsigned xs [2];
    if (r >= cfg_mirror.out_height || c >= cfg_mirror.out_width) return;
    s = locate(r, c);
    ys = '{s.y0, s.y1};
    xs = '{s.x0, s.x1};
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        if (!pix_known[ys[i] * bir_pkg::MAX_SRC_WIDTH + xs[j]])
          send_word(ACT_LOAD, bir_pkg::IDX_W'(ys[i]), bir_pkg::IDX_W'(xs[j]), pick_sample(),
                    1'b0, '0);
      end
    end
  endtask

  task automatic apb_write(input bir_pkg::reg_idx_t idx,
                           input logic [bir_pkg::PDATA_W-1:0] data);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    case (idx)
      bir_pkg::REG_SRC_WIDTH:  cfg_mirror.src_width  = data[bir_pkg::SRC_SZ_W-1:0];
      bir_pkg::REG_SRC_HEIGHT: cfg_mirror.src_height = data[bir_pkg::SRC_SZ_W-1:0];
      bir_pkg::REG_OUT_WIDTH:  cfg_mirror.out_width  = data[bir_pkg::OUT_SZ_W-1:0];
      bir_pkg::REG_OUT_HEIGHT: cfg_mirror.out_height = data[bir_pkg::OUT_SZ_W-1:0];
      bir_pkg::REG_X_STEP:     cfg_mirror.x_step     = data[bir_pkg::STEP_W-1:0];
      bir_pkg::REG_Y_STEP:     cfg_mirror.y_step     = data[bir_pkg::STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input int k);
    int sw, sh, ow, oh, xs, ys;
    case (k)
      0: begin
        sw = 2; sh = 2; ow = 1; oh = 1; xs = 0; ys = 0;
      end
      1: begin
        sw = 256; sh = 256; ow = 4096; oh = 4096; xs = 24'hFF0000; ys = 24'hFF0000;
      end
      2: begin
        sw = 256; sh = 3; ow = 4096; oh = 2; xs = (255 << 16) / 4096; ys = (2 << 16) / 2;
      end
      default: begin
        sw = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 16);
        sh = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 256) : $urandom_range(2, 16);
        ow = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
        oh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 48);
        xs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF0000) : ((sw - 1) << 16) / ow;
        ys = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFF0000) : ((sh - 1) << 16) / oh;
      end
    endcase
    apb_write(bir_pkg::REG_SRC_WIDTH, bir_pkg::PDATA_W'(sw));
    apb_write(bir_pkg::REG_SRC_HEIGHT, bir_pkg::PDATA_W'(sh));
    apb_write(bir_pkg::REG_OUT_WIDTH, bir_pkg::PDATA_W'(ow));
    apb_write(bir_pkg::REG_OUT_HEIGHT, bir_pkg::PDATA_W'(oh));
    apb_write(bir_pkg::REG_X_STEP, bir_pkg::PDATA_W'(xs));
    apb_write(bir_pkg::REG_Y_STEP, bir_pkg::PDATA_W'(ys));
    psel <= 1'b0;
    n_settings++;
  endtask

  task automatic random_word();
    int sel;
    int unsigned oh, ow;
    logic [bir_pkg::IDX_W-1:0] r, c;
    oh = (cfg_mirror.out_height > 4096) ? 4096 : cfg_mirror.out_height;
    ow = (cfg_mirror.out_width > 4096) ? 4096 : cfg_mirror.out_width;
    sel = $urandom_range(0, 99);
    if (sel >= 80 && sel < 88 && (oh < 4096 || ow < 4096)) begin
      if (oh < 4096 && (ow >= 4096 || $urandom_range(0, 1) == 1)) begin
        r = bir_pkg::IDX_W'($urandom_range(oh, 4095));
        c = bir_pkg::IDX_W'($urandom_range(0, 4095));
      end else begin
        r = bir_pkg::IDX_W'($urandom_range(0, 4095));
        c = bir_pkg::IDX_W'($urandom_range(ow, 4095));
      end
      send_word(ACT_QUERY, r, c, pick_sample(), 1'b0, '0);
    end else if (sel >= 62 && sel < 80) begin
      r = bir_pkg::IDX_W'($urandom_range(0, src_rows() - 1));
      c = bir_pkg::IDX_W'($urandom_range(0, src_cols() - 1));
      send_word(ACT_LOAD, r, c, pick_sample(), 1'b0, '0);
    end else if (sel >= 88) begin
      // noise: mostly outside the source, so the block drops it
      r = bir_pkg::IDX_W'($urandom);
      c = bir_pkg::IDX_W'($urandom);
      send_word(ACT_LOAD, r, c, pick_sample(), 1'b0, '0);
    end else begin
      r = bir_pkg::IDX_W'($urandom_range(0, oh - 1));
      c = bir_pkg::IDX_W'($urandom_range(0, ow - 1));
      prime_neighbors(r, c);
      send_word(ACT_QUERY, r, c, pick_sample(), 1'b0, '0);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // loads may still sit in the command queue
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      hold_left     <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: result word with none pending: value %h status %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_pixels.pop_front();
        n_checked++;
        if (m_axis_tdata !== want.value) begin
          n_errors++;
          $display("%0t: value mismatch: expected %h, got %h", $time, want.value, m_axis_tdata);
        end
        if (m_axis_tuser !== want.status) begin
          n_errors++;
          $display("%0t: status mismatch: expected %b, got %b",
                   $time, want.status, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    int mark;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) begin
      if (probes[i].act == ACT_QUERY) prime_neighbors(probes[i].row, probes[i].col);
      send_word(probes[i].act, probes[i].row, probes[i].col, probes[i].smp, probes[i].typed,
                pixel_t'{probes[i].value, probes[i].status});
    end

    for (int k = 0; k < PHASES; k++) begin
      settle();
      apply_setting(k);
      calm <= (k % 3 == 2);
      mark = n_words;
      while (n_words - mark < PER_PHASE) random_word();
    end
    settle();

    $display("Sent %0d words: %0d loads (%0d dropped), %0d queries (%0d outside the output)",
             n_words, n_loads, n_dropped, n_queries, n_outside);
    $display("Checked %0d results over %0d register settings, %0d mismatches",
             n_checked, n_settings, n_errors);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bir_pkg.sv
hw/rtl/bir_regs.sv
hw/rtl/bir_front.sv
hw/rtl/bir_cmd_fifo.sv
hw/rtl/bir_back.sv
hw/rtl/bilinear_image_resampler_core.sv
test/tb_bilinear_image_resampler_core.sv
